// ===== design/tgss_pkg.sv =====
// tgss_pkg: shared constants, register map, configuration struct and
// sequencer states for the trance gate step sequencer.
// No dependencies.
package tgss_pkg;

    localparam int NUM_STEPS   = 16;
    localparam int SAMPLE_BITS = 24;

    localparam int STEP_W   = 4;
    localparam int FRAC_W   = 32;
    localparam int PHASE_W  = STEP_W + FRAC_W;
    localparam int INT_W    = 16;
    localparam int POS_W    = 48;
    localparam int LEN_W    = 5;
    localparam int LEVEL_W  = 17;
    localparam int COEFF_W  = 16;
    localparam int SWING_W  = 8;
    localparam int GAIN_W   = 9;
    localparam int EFF_W    = 25;
    localparam int EFF_FRAC = 24;
    localparam int MUL_A_W  = LEVEL_W + 1;
    localparam int CNT_W    = 5;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;

    localparam int REM_STEPS   = INT_W - 1;
    localparam int LVL_STEPS   = COEFF_W;
    localparam int GAIN_STEPS  = GAIN_W;
    localparam int APPLY_STEPS = EFF_W;

    localparam logic [LEN_W-1:0]   LEN_MIN    = 5'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 17'h10000;
    localparam logic [GAIN_W-1:0]  GAIN_FULL  = 9'd256;
    localparam logic [EFF_W-1:0]   EFF_ONE    = 25'h1000000;

    typedef enum logic [2:0] {
        REG_LEVELS_LO,
        REG_LEVELS_HI,
        REG_LENGTH,
        REG_INCREMENT,
        REG_COEFF,
        REG_SWING,
        REG_DEPTH,
        REG_MIX
    } t_reg_idx;

    typedef struct packed {
        logic [63:0]         step_levels_low;
        logic [63:0]         step_levels_high;
        logic [LEN_W-1:0]    pattern_length;
        logic [FRAC_W-1:0]   phase_increment;
        logic [COEFF_W-1:0]  smooth_coeff;
        logic [SWING_W-1:0]  swing_amount;
        logic [GAIN_W-1:0]   gate_depth;
        logic [GAIN_W-1:0]   wet_mix;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        step_levels_low:  64'hFFFF_FFFF_FFFF_FFFF,
        step_levels_high: 64'hFFFF_FFFF_FFFF_FFFF,
        pattern_length:   5'd16,
        phase_increment:  32'd715828,
        smooth_coeff:     16'd114,
        swing_amount:     8'd0,
        gate_depth:       9'd256,
        wet_mix:          9'd256
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REM,
        ST_SWING,
        ST_TARGET,
        ST_LEVEL,
        ST_LVL_UPD,
        ST_GAIN_LD,
        ST_GAIN,
        ST_MIX_LD,
        ST_MIX,
        ST_APPLY_LD,
        ST_APPLY,
        ST_OUT
    } t_state;

endpackage

// ===== design/tgss_regs.sv =====
// tgss_regs: APB register file holding the gate configuration.
// Depends on tgss_pkg.
module tgss_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tgss_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [tgss_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [tgss_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output tgss_pkg::t_cfg                      o_cfg
);

    tgss_pkg::t_cfg     r_cfg;
    tgss_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = tgss_pkg::t_reg_idx'(paddr[tgss_pkg::CFG_ADDR_W-1:3]);
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tgss_pkg::CFG_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                tgss_pkg::REG_LEVELS_LO: r_cfg.step_levels_low  <= pwdata;
                tgss_pkg::REG_LEVELS_HI: r_cfg.step_levels_high <= pwdata;
                tgss_pkg::REG_LENGTH:    r_cfg.pattern_length   <= pwdata[tgss_pkg::LEN_W-1:0];
                tgss_pkg::REG_INCREMENT: r_cfg.phase_increment  <= pwdata[tgss_pkg::FRAC_W-1:0];
                tgss_pkg::REG_COEFF:     r_cfg.smooth_coeff     <= pwdata[tgss_pkg::COEFF_W-1:0];
                tgss_pkg::REG_SWING:     r_cfg.swing_amount     <= pwdata[tgss_pkg::SWING_W-1:0];
                tgss_pkg::REG_DEPTH:     r_cfg.gate_depth       <= pwdata[tgss_pkg::GAIN_W-1:0];
                tgss_pkg::REG_MIX:       r_cfg.wet_mix          <= pwdata[tgss_pkg::GAIN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tgss_pkg::REG_LEVELS_LO: prdata = r_cfg.step_levels_low;
            tgss_pkg::REG_LEVELS_HI: prdata = r_cfg.step_levels_high;
            tgss_pkg::REG_LENGTH:    prdata = tgss_pkg::CFG_DATA_W'(r_cfg.pattern_length);
            tgss_pkg::REG_INCREMENT: prdata = tgss_pkg::CFG_DATA_W'(r_cfg.phase_increment);
            tgss_pkg::REG_COEFF:     prdata = tgss_pkg::CFG_DATA_W'(r_cfg.smooth_coeff);
            tgss_pkg::REG_SWING:     prdata = tgss_pkg::CFG_DATA_W'(r_cfg.swing_amount);
            tgss_pkg::REG_DEPTH:     prdata = tgss_pkg::CFG_DATA_W'(r_cfg.gate_depth);
            tgss_pkg::REG_MIX:       prdata = tgss_pkg::CFG_DATA_W'(r_cfg.wet_mix);
        endcase
    end

endmodule

// ===== design/tgss_srem.sv =====
// tgss_srem: bit-serial floor remainder of a signed integer by the pattern
// length, one bit per cycle while i_run is high, MSB first. Depends on tgss_pkg.
module tgss_srem (
    input  logic                             i_clk,
    input  logic                             i_load,
    input  logic                             i_run,
    input  logic [tgss_pkg::INT_W-1:0]       i_value,
    input  logic [tgss_pkg::LEN_W-1:0]       i_len,
    output logic [tgss_pkg::STEP_W-1:0]      o_rem
);

    logic [tgss_pkg::INT_W-1:0] r_bits;
    logic [tgss_pkg::LEN_W-1:0] r_rem;
    logic [tgss_pkg::LEN_W-1:0] trial;

    // sign bit weighs -2^15: its residue is len-1 when set
    assign trial = {r_rem[tgss_pkg::STEP_W-1:0], r_bits[tgss_pkg::INT_W-1]};
    assign o_rem = r_rem[tgss_pkg::STEP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= i_value[tgss_pkg::INT_W-1] ? i_len - tgss_pkg::LEN_W'(1) : '0;
            r_bits <= {i_value[tgss_pkg::INT_W-2:0], 1'b0};
        end else if (i_run) begin
            r_rem  <= (trial >= i_len) ? trial - i_len : trial;
            r_bits <= {r_bits[tgss_pkg::INT_W-2:0], 1'b0};
        end
    end

endmodule

// ===== design/tgss_smul.sv =====
// tgss_smul: shift-add serial multiplier, signed multiplicand times unsigned
// multiplier, one multiplier bit per cycle while i_run is high, LSB first. Depends on nothing.
module tgss_smul #(
    parameter int A_W = 18,
    parameter int B_W = 16
) (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic                   i_run,
    input  logic [A_W-1:0]         i_a,
    input  logic [B_W-1:0]         i_b,
    output logic [A_W+B_W-1:0]     o_prod
);

    logic [A_W-1:0] r_mcand;
    logic [A_W:0]   r_hi;
    logic [B_W-1:0] r_lo;
    logic [A_W:0]   addend;
    logic [A_W:0]   sum;

    assign addend = r_lo[0] ? {r_mcand[A_W-1], r_mcand} : '0;
    assign sum    = r_hi + addend;
    assign o_prod = {r_hi[A_W-1:0], r_lo};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mcand <= i_a;
            r_hi    <= '0;
            r_lo    <= i_b;
        end else if (i_run) begin
            r_hi <= {sum[A_W], sum[A_W:1]};
            r_lo <= {sum[0], r_lo[B_W-1:1]};
        end
    end

endmodule

// ===== design/trance_gate_step_sequencer_top.sv =====
// Trance gate step sequencer, one stereo sample pair per transfer. An item is
// taken only while the sequencer is idle and then passes in order through a
// bit-serial remainder for the pattern position, the smoothing multiply (one
// step per coefficient bit), the depth and mix multiplies and the two sample
// multiplies running side by side (one step per gain bit), with setup and
// lookup states between them, before its result reaches the output register.
// The next item is taken while a finished result waits in the output
// register. Registers sit at byte address 8*index, 64-bit data.
// Depends on tgss_pkg, tgss_regs, tgss_srem, tgss_smul.
module trance_gate_step_sequencer_top #(
    parameter  int SAMPLE_BITS = tgss_pkg::SAMPLE_BITS,
    localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + tgss_pkg::POS_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((2 * SAMPLE_BITS + tgss_pkg::STEP_W
                                   + tgss_pkg::LEVEL_W + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // left_in, right_in, song_position
    input  logic [IN_TDATA_W-1:0]              i_s_axis_tdata,
    // locked
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // left_out, right_out, current_step, gate_level
    output logic [OUT_TDATA_W-1:0]             o_m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tgss_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [tgss_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [tgss_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int SB    = SAMPLE_BITS;
    localparam int APP_W = SB + tgss_pkg::EFF_W;
    localparam int OUT_W = 2 * SB + tgss_pkg::STEP_W + tgss_pkg::LEVEL_W;

    tgss_pkg::t_cfg   cfg;
    tgss_pkg::t_state r_state;
    tgss_pkg::t_state n_state;
    logic [tgss_pkg::CNT_W-1:0] r_cnt;

    logic in_acc;
    logic rem_run, lvl_load, lvl_run, gn_load, gn_run, app_load, app_run;
    logic phase_wr, level_wr, out_load;

    logic [SB-1:0]                   r_left, r_right;
    logic [tgss_pkg::FRAC_W-1:0]     r_frac;
    logic [tgss_pkg::PHASE_W-1:0]    r_phase;
    logic [tgss_pkg::LEVEL_W-1:0]    r_level;
    logic [tgss_pkg::STEP_W-1:0]     r_step;

    logic                            r_out_valid;
    logic [SB-1:0]                   r_out_left, r_out_right;
    logic [tgss_pkg::STEP_W-1:0]     r_out_step;
    logic [tgss_pkg::LEVEL_W-1:0]    r_out_level;

    logic [tgss_pkg::PHASE_W:0]      run_sum;
    logic [tgss_pkg::POS_W-1:0]      in_pos;
    logic [tgss_pkg::INT_W-1:0]      rem_value;
    logic [tgss_pkg::LEN_W-1:0]      len_eff;
    logic [tgss_pkg::STEP_W-1:0]     rem_q;

    logic [tgss_pkg::FRAC_W+8:0]     swing_prod;
    logic                            swing_hold;
    logic [tgss_pkg::STEP_W-1:0]     use_step;

    logic [127:0]                    levels;
    logic [7:0]                      step_val;
    logic [tgss_pkg::LEVEL_W-1:0]    target;
    logic [tgss_pkg::MUL_A_W-1:0]    diff;

    logic [tgss_pkg::MUL_A_W+tgss_pkg::COEFF_W-1:0] lvl_prod;
    logic [tgss_pkg::MUL_A_W+tgss_pkg::COEFF_W-1:0] lvl_round;
    logic [tgss_pkg::MUL_A_W-1:0]    delta;
    logic [tgss_pkg::MUL_A_W:0]      lvl_sum;
    logic [tgss_pkg::LEVEL_W-1:0]    lvl_next;

    logic [tgss_pkg::GAIN_W-1:0]     depth_c, mix_c;
    logic [tgss_pkg::MUL_A_W-1:0]    gn_a;
    logic [tgss_pkg::GAIN_W-1:0]     gn_b;
    logic [tgss_pkg::MUL_A_W+tgss_pkg::GAIN_W-1:0] gn_prod;
    logic [tgss_pkg::MUL_A_W+tgss_pkg::GAIN_W-1:0] gn_round;
    logic [tgss_pkg::EFF_W-1:0]      eff;

    logic [APP_W-1:0]                app_l_prod, app_r_prod;
    logic [SB-1:0]                   y_left, y_right;

    function automatic logic [SB-1:0] round_sat(input logic [APP_W-1:0] p);
        logic [APP_W-1:0] q;
        logic [SB:0]      y;
        q = p + APP_W'(1 << (tgss_pkg::EFF_FRAC - 1));
        y = q[APP_W-1:tgss_pkg::EFF_FRAC];
        if (y[SB] != y[SB-1]) begin
            round_sat = y[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end else begin
            round_sat = y[SB-1:0];
        end
    endfunction

    tgss_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ---------------- handshake and sequencer ----------------
    assign o_s_axis_tready = (r_state == tgss_pkg::ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tgss_pkg::ST_IDLE:     if (in_acc) n_state = tgss_pkg::ST_REM;
            tgss_pkg::ST_REM: begin
                if (r_cnt == tgss_pkg::CNT_W'(tgss_pkg::REM_STEPS - 1))
                    n_state = tgss_pkg::ST_SWING;
            end
            tgss_pkg::ST_SWING:    n_state = tgss_pkg::ST_TARGET;
            tgss_pkg::ST_TARGET:   n_state = tgss_pkg::ST_LEVEL;
            tgss_pkg::ST_LEVEL: begin
                if (r_cnt == tgss_pkg::CNT_W'(tgss_pkg::LVL_STEPS - 1))
                    n_state = tgss_pkg::ST_LVL_UPD;
            end
            tgss_pkg::ST_LVL_UPD:  n_state = tgss_pkg::ST_GAIN_LD;
            tgss_pkg::ST_GAIN_LD:  n_state = tgss_pkg::ST_GAIN;
            tgss_pkg::ST_GAIN: begin
                if (r_cnt == tgss_pkg::CNT_W'(tgss_pkg::GAIN_STEPS - 1))
                    n_state = tgss_pkg::ST_MIX_LD;
            end
            tgss_pkg::ST_MIX_LD:   n_state = tgss_pkg::ST_MIX;
            tgss_pkg::ST_MIX: begin
                if (r_cnt == tgss_pkg::CNT_W'(tgss_pkg::GAIN_STEPS - 1))
                    n_state = tgss_pkg::ST_APPLY_LD;
            end
            tgss_pkg::ST_APPLY_LD: n_state = tgss_pkg::ST_APPLY;
            tgss_pkg::ST_APPLY: begin
                if (r_cnt == tgss_pkg::CNT_W'(tgss_pkg::APPLY_STEPS - 1))
                    n_state = tgss_pkg::ST_OUT;
            end
            tgss_pkg::ST_OUT: begin
                if (!r_out_valid || i_m_axis_tready) n_state = tgss_pkg::ST_IDLE;
            end
            default:               n_state = tgss_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        rem_run  = 1'b0;
        lvl_load = 1'b0;
        lvl_run  = 1'b0;
        gn_load  = 1'b0;
        gn_run   = 1'b0;
        app_load = 1'b0;
        app_run  = 1'b0;
        phase_wr = 1'b0;
        level_wr = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            tgss_pkg::ST_REM:      rem_run  = 1'b1;
            tgss_pkg::ST_SWING:    phase_wr = 1'b1;
            tgss_pkg::ST_TARGET:   lvl_load = 1'b1;
            tgss_pkg::ST_LEVEL:    lvl_run  = 1'b1;
            tgss_pkg::ST_LVL_UPD:  level_wr = 1'b1;
            tgss_pkg::ST_GAIN_LD,
            tgss_pkg::ST_MIX_LD:   gn_load  = 1'b1;
            tgss_pkg::ST_GAIN,
            tgss_pkg::ST_MIX:      gn_run   = 1'b1;
            tgss_pkg::ST_APPLY_LD: app_load = 1'b1;
            tgss_pkg::ST_APPLY:    app_run  = 1'b1;
            tgss_pkg::ST_OUT:      out_load = !r_out_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tgss_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state != n_state) ? '0 : r_cnt + tgss_pkg::CNT_W'(1);
        end
    end

    // ---------------- pattern position ----------------
    assign in_pos  = i_s_axis_tdata[2*SB +: tgss_pkg::POS_W];
    assign run_sum = {1'b0, r_phase} + (tgss_pkg::PHASE_W + 1)'(cfg.phase_increment);

    always_comb begin
        if (cfg.pattern_length < tgss_pkg::LEN_MIN) begin
            len_eff = tgss_pkg::LEN_MIN;
        end else if (cfg.pattern_length > tgss_pkg::LEN_W'(tgss_pkg::NUM_STEPS)) begin
            len_eff = tgss_pkg::LEN_W'(tgss_pkg::NUM_STEPS);
        end else begin
            len_eff = cfg.pattern_length;
        end
    end

    assign rem_value = i_s_axis_tuser
                     ? in_pos[tgss_pkg::POS_W-1:tgss_pkg::FRAC_W]
                     : tgss_pkg::INT_W'(run_sum[tgss_pkg::PHASE_W:tgss_pkg::FRAC_W]);

    tgss_srem u_srem (
        .i_clk   (i_clk),
        .i_load  (in_acc),
        .i_run   (rem_run),
        .i_value (rem_value),
        .i_len   (len_eff),
        .o_rem   (rem_q)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_left  <= i_s_axis_tdata[SB-1:0];
            r_right <= i_s_axis_tdata[2*SB-1:SB];
            r_frac  <= i_s_axis_tuser ? in_pos[tgss_pkg::FRAC_W-1:0]
                                      : run_sum[tgss_pkg::FRAC_W-1:0];
        end
    end

    // swing: frac * 510 < swing * 2^32, compared on the integer part
    assign swing_prod = {r_frac, 9'b0} - {8'b0, r_frac, 1'b0};
    assign swing_hold = (cfg.swing_amount != '0) && rem_q[0]
                     && (swing_prod[tgss_pkg::FRAC_W+8:tgss_pkg::FRAC_W]
                         < {1'b0, cfg.swing_amount});
    assign use_step   = swing_hold ? rem_q - tgss_pkg::STEP_W'(1) : rem_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (phase_wr) begin
            r_phase <= {rem_q, r_frac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (phase_wr) r_step <= use_step;
    end

    // ---------------- level smoothing ----------------
    assign levels   = {cfg.step_levels_high, cfg.step_levels_low};
    assign step_val = levels[{r_step, 3'b000} +: 8];
    // v * 65536 / 255 rounded: v * 257 plus one for the upper half
    assign target   = {1'b0, step_val, step_val} + tgss_pkg::LEVEL_W'(step_val[7]);
    assign diff     = {1'b0, target} - {1'b0, r_level};

    tgss_smul #(
        .A_W (tgss_pkg::MUL_A_W),
        .B_W (tgss_pkg::COEFF_W)
    ) u_mul_lvl (
        .i_clk  (i_clk),
        .i_load (lvl_load),
        .i_run  (lvl_run),
        .i_a    (diff),
        .i_b    (cfg.smooth_coeff),
        .o_prod (lvl_prod)
    );

    assign lvl_round = lvl_prod + (tgss_pkg::MUL_A_W + tgss_pkg::COEFF_W)'(32768);
    assign delta     = lvl_round[tgss_pkg::MUL_A_W+tgss_pkg::COEFF_W-1:tgss_pkg::COEFF_W];
    assign lvl_sum   = {2'b00, r_level} + {delta[tgss_pkg::MUL_A_W-1], delta};

    always_comb begin
        if (lvl_sum[tgss_pkg::MUL_A_W]) begin
            lvl_next = '0;
        end else if (lvl_sum[tgss_pkg::MUL_A_W-1:0] > {1'b0, tgss_pkg::LEVEL_ONE}) begin
            lvl_next = tgss_pkg::LEVEL_ONE;
        end else begin
            lvl_next = lvl_sum[tgss_pkg::LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= tgss_pkg::LEVEL_ONE;
        end else if (level_wr) begin
            r_level <= lvl_next;
        end
    end

    // ---------------- depth and mix ----------------
    assign depth_c = (cfg.gate_depth > tgss_pkg::GAIN_FULL) ? tgss_pkg::GAIN_FULL
                                                            : cfg.gate_depth;
    assign mix_c   = (cfg.wet_mix > tgss_pkg::GAIN_FULL) ? tgss_pkg::GAIN_FULL
                                                         : cfg.wet_mix;

    // 65536 - g equals the rounded depth product
    assign gn_round = gn_prod + (tgss_pkg::MUL_A_W + tgss_pkg::GAIN_W)'(128);
    assign gn_a     = (r_state == tgss_pkg::ST_MIX_LD)
                    ? gn_round[tgss_pkg::MUL_A_W+7:8]
                    : {1'b0, tgss_pkg::LEVEL_ONE} - {1'b0, r_level};
    assign gn_b     = (r_state == tgss_pkg::ST_MIX_LD) ? mix_c : depth_c;

    tgss_smul #(
        .A_W (tgss_pkg::MUL_A_W),
        .B_W (tgss_pkg::GAIN_W)
    ) u_mul_gain (
        .i_clk  (i_clk),
        .i_load (gn_load),
        .i_run  (gn_run),
        .i_a    (gn_a),
        .i_b    (gn_b),
        .o_prod (gn_prod)
    );

    assign eff = tgss_pkg::EFF_ONE - gn_prod[tgss_pkg::EFF_W-1:0];

    // ---------------- sample gain, both channels ----------------
    tgss_smul #(
        .A_W (SB),
        .B_W (tgss_pkg::EFF_W)
    ) u_mul_left (
        .i_clk  (i_clk),
        .i_load (app_load),
        .i_run  (app_run),
        .i_a    (r_left),
        .i_b    (eff),
        .o_prod (app_l_prod)
    );

    tgss_smul #(
        .A_W (SB),
        .B_W (tgss_pkg::EFF_W)
    ) u_mul_right (
        .i_clk  (i_clk),
        .i_load (app_load),
        .i_run  (app_run),
        .i_a    (r_right),
        .i_b    (eff),
        .o_prod (app_r_prod)
    );

    assign y_left  = round_sat(app_l_prod);
    assign y_right = round_sat(app_r_prod);

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && !i_m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_left  <= y_left;
            r_out_right <= y_right;
            r_out_step  <= r_step;
            r_out_level <= r_level;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_level, r_out_step, r_out_right, r_out_left});

endmodule

// ===== design/tgss_checker.sv =====
// tgss_checker: port-level assertions for the trance gate step sequencer,
// bound to the top level. Depends on tgss_pkg.
module tgss_checker #(
    parameter  int SAMPLE_BITS = tgss_pkg::SAMPLE_BITS,
    localparam int OUT_TDATA_W = ((2 * SAMPLE_BITS + tgss_pkg::STEP_W
                                   + tgss_pkg::LEVEL_W + 7) / 8) * 8,
    localparam int LVL_LSB     = 2 * SAMPLE_BITS + tgss_pkg::STEP_W
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_s_axis_tvalid,
    input logic                    o_s_axis_tready,
    input logic                    o_m_axis_tvalid,
    input logic                    i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output transfer dropped while stalled");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[LVL_LSB +: tgss_pkg::LEVEL_W] <= tgss_pkg::LEVEL_ONE)
        else $error("gate level above unity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken again while an item is in progress");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("reset did not leave the block idle and empty");

endmodule

bind trance_gate_step_sequencer_top tgss_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_tgss_checker (.*);
